[hw/rtl/kbps_pkg.sv]
// Shared types, constants and lookup functions for the bicycle pose integrator.
package kbps_pkg;

    // Heading constants in Q3.13 radians.
    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;

    // Steering limit in Q2.14 radians (1.4 rad).
    localparam logic signed [15:0] STEER_MAX = 16'sd22938;

    // Rotation engine constants in Q2.30.
    localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
    localparam logic signed [32:0] ONE_Q30      = 33'sd1073741824;
    localparam logic signed [31:0] COS_FLOOR    = 32'sd67108864;

    // Number of micro-rotations per angle.
    localparam int unsigned CORDIC_STEPS = 16;

    // Cosine and sine pair from the rotation engine, Q2.30.
    typedef struct packed {
        logic signed [31:0] cos_q30;
        logic signed [31:0] sin_q30;
    } trig_t;

    // Arctangent of 2^-idx in Q16 radians, rounded to nearest.
    function automatic logic [16:0] atan_q16(input logic [3:0] idx);
        logic [16:0] val;
        case (idx)
            4'd0:    val = 17'd51472;
            4'd1:    val = 17'd30386;
            4'd2:    val = 17'd16055;
            4'd3:    val = 17'd8150;
            4'd4:    val = 17'd4091;
            4'd5:    val = 17'd2047;
            4'd6:    val = 17'd1024;
            4'd7:    val = 17'd512;
            4'd8:    val = 17'd256;
            4'd9:    val = 17'd128;
            4'd10:   val = 17'd64;
            4'd11:   val = 17'd32;
            4'd12:   val = 17'd16;
            4'd13:   val = 17'd8;
            4'd14:   val = 17'd4;
            default: val = 17'd2;
        endcase
        return val;
    endfunction

    // Limit a rotation result to plus or minus one.
    function automatic logic signed [31:0] clamp_unit(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v > ONE_Q30) begin
            res = ONE_Q30[31:0];
        end
        else if (v < -ONE_Q30) begin
            res = 32'(-ONE_Q30);
        end
        else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/kinematic_bicycle_pose_step.sv]
// Top level of the kinematic bicycle pose integrator with its register port.
// Each accepted beat (speed, steer) advances the pose by one Euler step and gives one
// result beat (pos_x, pos_y, heading). The work runs on three bit-serial units shared by
// a sequencer: a rotation engine (used twice), a shift-and-add multiplier (used three
// times) and a restoring divider (used twice, for the tangent and for the heading change).
// Each use is launched through a start register; after the last division come a wrap step
// and the result register, and only then is the sequencer back at rest for the next beat.
// The final step waits while a previous result beat is still stalled; a new
// input beat is taken as soon as the sequencer is back at rest. Registers are wheelbase
// at byte address 0 and time_step at byte address 4; write them only while idle.
module kinematic_bicycle_pose_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        speed,
    input  logic signed [15:0] steer,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [15:0] heading,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import kbps_pkg::*;

    // Register indexes.
    localparam logic REG_WHEELBASE = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIG_POSE,
        S_MUL_X,
        S_MUL_Y,
        S_TRIG_STEER,
        S_DIV_TAN,
        S_MUL_YAW,
        S_DIV_YAW,
        S_WRAP,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [15:0]        wheelbase_reg;
    logic [15:0]        time_step_reg;
    logic signed [31:0] x_acc_reg;
    logic signed [31:0] y_acc_reg;
    logic signed [15:0] yaw_acc_reg;

    logic [31:0]        vdt_reg;
    logic [14:0]        steer_mag_reg;
    logic               neg_steer_reg;
    logic               neg_trig_reg;
    logic               sin_neg_reg;
    logic [15:0]        wb_eff_reg;
    logic [15:0]        mod_reg;

    logic               cordic_start_reg;
    logic signed [19:0] cordic_z_reg;
    logic               mul_start_reg;
    logic [31:0]        mul_b_reg;
    logic               div_start_reg;
    logic [63:0]        div_dividend_reg;
    logic [31:0]        div_divisor_reg;

    logic               out_valid_reg;
    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_y_reg;
    logic signed [15:0] heading_reg;

    trig_t              trig;
    logic               cordic_done;
    logic [63:0]        mul_product;
    logic               mul_done;
    logic [63:0]        div_quotient;
    logic               div_q_bit;
    logic               div_q_valid;
    logic               div_done;

    logic               in_fire;
    logic               cfg_write;
    logic signed [15:0] steer_clamped;
    logic [14:0]        steer_abs;
    logic signed [19:0] yaw_ext;
    logic signed [19:0] yaw_shift;
    logic signed [19:0] z_pose;
    logic signed [31:0] cos_sel;
    logic signed [31:0] sin_sel;
    logic [31:0]        cos_abs;
    logic [31:0]        sin_abs;
    logic [63:0]        round_sum;
    logic [21:0]        step_mag;
    logic signed [32:0] x_sum;
    logic signed [32:0] y_sum;
    logic signed [31:0] x_sat;
    logic signed [31:0] y_sat;
    logic [31:0]        tan_num;
    logic [31:0]        tan_den;
    logic [63:0]        yaw_num;
    logic [16:0]        mod_trial;
    logic [15:0]        mod_next;
    logic signed [17:0] yaw_base;
    logic signed [17:0] yaw_t;
    logic signed [17:0] yaw_new;

    // Handshakes.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register read data.
    always_comb
    begin
        unique case (paddr[2])
            REG_WHEELBASE: prdata = {16'd0, wheelbase_reg};
            REG_TIME_STEP: prdata = {16'd0, time_step_reg};
            default:       prdata = '0;
        endcase
    end

    // Steering clamp and the folded pose angle.
    always_comb
    begin
        if (steer > STEER_MAX) begin
            steer_clamped = STEER_MAX;
        end
        else if (steer < -STEER_MAX) begin
            steer_clamped = -STEER_MAX;
        end
        else begin
            steer_clamped = steer;
        end
        steer_abs = steer_clamped[15] ? 15'(-steer_clamped) : steer_clamped[14:0];

        yaw_ext = 20'(yaw_acc_reg);
        if (yaw_ext > 20'(HALF_PI_Q13)) begin
            yaw_shift = yaw_ext - 20'(PI_Q13);
        end
        else if (yaw_ext < -20'(HALF_PI_Q13)) begin
            yaw_shift = yaw_ext + 20'(PI_Q13);
        end
        else begin
            yaw_shift = yaw_ext;
        end
        z_pose = yaw_shift <<< 3;
    end

    // Rotation results with the half-turn fold undone, their magnitudes and the tangent operands.
    always_comb
    begin
        cos_sel = neg_trig_reg ? -trig.cos_q30 : trig.cos_q30;
        sin_sel = neg_trig_reg ? -trig.sin_q30 : trig.sin_q30;
        cos_abs = cos_sel[31] ? 32'(-cos_sel) : cos_sel;
        sin_abs = sin_sel[31] ? 32'(-sin_sel) : sin_sel;
        tan_num = trig.sin_q30[31] ? 32'd0 : trig.sin_q30;
        tan_den = (trig.cos_q30 < COS_FLOOR) ? COS_FLOOR : trig.cos_q30;
    end

    // Position step rounding and saturating accumulation.
    always_comb
    begin
        round_sum = mul_product + (64'd1 << 41);
        step_mag  = round_sum[63:42];
        x_sum = 33'(x_acc_reg) + (neg_trig_reg ? -33'(step_mag) : 33'(step_mag));
        y_sum = 33'(y_acc_reg) + (sin_neg_reg ? -33'(step_mag) : 33'(step_mag));
        if (x_sum[32] != x_sum[31]) begin
            x_sat = x_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else begin
            x_sat = x_sum[31:0];
        end
        if (y_sum[32] != y_sum[31]) begin
            y_sat = y_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else begin
            y_sat = y_sum[31:0];
        end
    end

    // Heading change: rounded dividend, running remainder of the quotient, wrap.
    always_comb
    begin
        yaw_num   = mul_product + {30'd0, wb_eff_reg, 18'd0};
        mod_trial = {mod_reg, div_q_bit};
        if (mod_trial >= 17'(TWO_PI_Q13)) begin
            mod_next = 16'(mod_trial - 17'(TWO_PI_Q13));
        end
        else begin
            mod_next = mod_trial[15:0];
        end
        yaw_base = 18'(yaw_acc_reg) + PI_Q13;
        if (neg_steer_reg) begin
            yaw_t = yaw_base - signed'({2'b00, mod_reg});
            if (yaw_t < 0) begin
                yaw_t = yaw_t + TWO_PI_Q13;
            end
        end
        else begin
            yaw_t = yaw_base + signed'({2'b00, mod_reg});
            if (yaw_t >= TWO_PI_Q13) begin
                yaw_t = yaw_t - TWO_PI_Q13;
            end
        end
        yaw_new = yaw_t - PI_Q13;
    end

    // Sequencer, pose state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= S_IDLE;
            wheelbase_reg    <= 16'd1229;
            time_step_reg    <= 16'd1311;
            x_acc_reg        <= '0;
            y_acc_reg        <= '0;
            yaw_acc_reg      <= '0;
            vdt_reg          <= '0;
            steer_mag_reg    <= '0;
            neg_steer_reg    <= 1'b0;
            neg_trig_reg     <= 1'b0;
            sin_neg_reg      <= 1'b0;
            wb_eff_reg       <= 16'd1;
            mod_reg          <= '0;
            cordic_start_reg <= 1'b0;
            cordic_z_reg     <= '0;
            mul_start_reg    <= 1'b0;
            mul_b_reg        <= '0;
            div_start_reg    <= 1'b0;
            div_dividend_reg <= '0;
            div_divisor_reg  <= '0;
            out_valid_reg    <= 1'b0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            heading_reg      <= '0;
        end
        else begin
            cordic_start_reg <= 1'b0;
            mul_start_reg    <= 1'b0;
            div_start_reg    <= 1'b0;

            if (cfg_write) begin
                unique case (paddr[2])
                    REG_WHEELBASE: wheelbase_reg <= pwdata[15:0];
                    REG_TIME_STEP: time_step_reg <= pwdata[15:0];
                    default:       wheelbase_reg <= wheelbase_reg;
                endcase
            end

            // A taken result beat clears the output unless a new one replaces it.
            if (out_valid_reg && !out_stall && state_reg != S_DONE) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire) begin
                        vdt_reg          <= 32'(speed) * 32'(time_step_reg);
                        steer_mag_reg    <= steer_abs;
                        neg_steer_reg    <= steer_clamped[15];
                        neg_trig_reg     <= (yaw_ext > 20'(HALF_PI_Q13)) ||
                                            (yaw_ext < -20'(HALF_PI_Q13));
                        wb_eff_reg       <= (wheelbase_reg == 16'd0) ? 16'd1 : wheelbase_reg;
                        cordic_z_reg     <= z_pose;
                        cordic_start_reg <= 1'b1;
                        state_reg        <= S_TRIG_POSE;
                    end
                end
                S_TRIG_POSE:
                begin
                    if (cordic_done) begin
                        // Keep the signs; neg_trig_reg now holds the cosine sign.
                        // The sine magnitude waits in the divisor register for the y pass.
                        neg_trig_reg    <= cos_sel[31];
                        sin_neg_reg     <= sin_sel[31];
                        mul_b_reg       <= cos_abs;
                        div_divisor_reg <= sin_abs;
                        mul_start_reg   <= 1'b1;
                        state_reg       <= S_MUL_X;
                    end
                end
                S_MUL_X:
                begin
                    if (mul_done) begin
                        x_acc_reg     <= x_sat;
                        mul_b_reg     <= div_divisor_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_Y;
                    end
                end
                S_MUL_Y:
                begin
                    if (mul_done) begin
                        y_acc_reg        <= y_sat;
                        cordic_z_reg     <= signed'({3'b000, steer_mag_reg, 2'b00});
                        cordic_start_reg <= 1'b1;
                        state_reg        <= S_TRIG_STEER;
                    end
                end
                S_TRIG_STEER:
                begin
                    if (cordic_done) begin
                        div_dividend_reg <= {16'd0, tan_num, 16'd0};
                        div_divisor_reg  <= tan_den;
                        div_start_reg    <= 1'b1;
                        state_reg        <= S_DIV_TAN;
                    end
                end
                S_DIV_TAN:
                begin
                    if (div_done) begin
                        mul_b_reg     <= {11'd0, div_quotient[20:0]};
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_MUL_YAW;
                    end
                end
                S_MUL_YAW:
                begin
                    if (mul_done) begin
                        div_dividend_reg <= {19'd0, yaw_num[63:19]};
                        div_divisor_reg  <= {16'd0, wb_eff_reg};
                        div_start_reg    <= 1'b1;
                        mod_reg          <= '0;
                        state_reg        <= S_DIV_YAW;
                    end
                end
                S_DIV_YAW:
                begin
                    if (div_q_valid) begin
                        mod_reg <= mod_next;
                    end
                    if (div_done) begin
                        state_reg <= S_WRAP;
                    end
                end
                S_WRAP:
                begin
                    yaw_acc_reg <= yaw_new[15:0];
                    state_reg   <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall) begin
                        out_valid_reg <= 1'b1;
                        pos_x_reg     <= x_acc_reg;
                        pos_y_reg     <= y_acc_reg;
                        heading_reg   <= yaw_acc_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    kbps_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start_reg),
        .z_in  (cordic_z_reg),
        .trig  (trig),
        .done  (cordic_done)
    );

    kbps_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (vdt_reg),
        .b       (mul_b_reg),
        .product (mul_product),
        .done    (mul_done)
    );

    kbps_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend_reg),
        .divisor  (div_divisor_reg),
        .quotient (div_quotient),
        .q_bit    (div_q_bit),
        .q_valid  (div_q_valid),
        .done     (div_done)
    );

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign heading   = heading_reg;

`ifndef SYNTHESIS
    // An accepted beat keeps the sequencer busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> in_stall)
        else $error("input taken while the sequencer is at rest after an accept");

    // The stored heading always lies in the wrapped range.
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        (yaw_acc_reg >= -16'sd25736) && (yaw_acc_reg <= 16'sd25735))
        else $error("heading state outside the wrapped range");

    // A result beat only appears after the wrap step has finished.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the final step");
`endif

endmodule

[hw/rtl/kbps_cordic.sv]
// Iterative rotation engine: one micro-rotation per cycle, gives cosine and sine.
module kbps_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [19:0]   z_in,
    output kbps_pkg::trig_t      trig,
    output logic                 done
);
    import kbps_pkg::*;

    logic signed [32:0] x_reg;
    logic signed [32:0] y_reg;
    logic signed [19:0] z_reg;
    logic [3:0]         idx_reg;
    logic               busy_reg;
    logic               done_reg;

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [19:0] ang;

    // Shifted cross terms and the angle of this step.
    always_comb
    begin
        dx  = y_reg >>> idx_reg;
        dy  = x_reg >>> idx_reg;
        ang = signed'({3'b000, atan_q16(idx_reg)});
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                idx_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg) begin
                idx_reg <= idx_reg + 4'd1;
                if (idx_reg == 4'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Vector and residual angle.
    always_ff @(posedge clk)
    begin
        if (start) begin
            x_reg <= CORDIC_START;
            y_reg <= '0;
            z_reg <= z_in;
        end
        else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ang;
            end
            else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ang;
            end
        end
    end

    assign trig.cos_q30 = clamp_unit(x_reg);
    assign trig.sin_q30 = clamp_unit(y_reg);
    assign done         = done_reg;

endmodule

[hw/rtl/kbps_serial_mul.sv]
// Bit-serial shift-and-add multiplier, 32 by 32 bits, one multiplier bit per cycle.
module kbps_serial_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] product,
    output logic        done
);
    import kbps_pkg::*;

    logic [63:0] prod_reg;
    logic [31:0] a_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] part_sum;

    // Add the multiplicand into the upper half when the low bit is set.
    always_comb
    begin
        part_sum = {1'b0, prod_reg[63:32]} + (prod_reg[0] ? {1'b0, a_reg} : 33'd0);
    end

    // Bit counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial product shifts right one place per step.
    always_ff @(posedge clk)
    begin
        if (start) begin
            a_reg    <= a;
            prod_reg <= {32'd0, b};
        end
        else if (busy_reg) begin
            prod_reg <= {part_sum, prod_reg[31:1]};
        end
    end

    assign product = prod_reg;
    assign done    = done_reg;

endmodule

[hw/rtl/kbps_serial_div.sv]
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module kbps_serial_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        q_bit,
    output logic        q_valid,
    output logic        done
);
    import kbps_pkg::*;

    logic [63:0] num_reg;
    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] div_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        qbit_reg;
    logic        qvalid_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    // Bring down the next dividend bit and try the subtraction.
    always_comb
    begin
        trial = {rem_reg, num_reg[63]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Step counter and per-bit strobes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            qvalid_reg <= 1'b0;
        end
        else begin
            done_reg   <= 1'b0;
            qvalid_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg) begin
                cnt_reg    <= cnt_reg + 6'd1;
                qvalid_reg <= 1'b1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, dividend and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start) begin
            num_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg) begin
            num_reg  <= {num_reg[62:0], 1'b0};
            rem_reg  <= fits ? diff[31:0] : trial[31:0];
            quo_reg  <= {quo_reg[62:0], fits};
            qbit_reg <= fits;
        end
    end

    assign quotient = quo_reg;
    assign q_bit    = qbit_reg;
    assign q_valid  = qvalid_reg;
    assign done     = done_reg;

endmodule

[sim/kinematic_bicycle_pose_step_tb.sv]
// Self-checking testbench for the kinematic bicycle pose integrator.
module kinematic_bicycle_pose_step_tb;

    // Register addresses on the configuration port.
    localparam logic [2:0] ADDR_WHEELBASE = 3'd0;
    localparam logic [2:0] ADDR_TIME_STEP = 3'd4;

    // Fixed-point constants of the pose arithmetic and the bench limits.
    localparam longint HEAD_PI      = 25736;
    localparam longint HEAD_HALF_PI = 12868;
    localparam longint HEAD_TWO_PI  = 51472;
    localparam longint STEER_LIMIT  = 22938;
    localparam longint ROT_START    = 652032874;
    localparam longint UNIT_Q30     = 1073741824;
    localparam longint TAN_COS_MIN  = 67108864;
    localparam int     WATCHDOG_MAX = 20000;
    localparam int     DRAIN_CYCLES = 600;
    localparam int     HOLD_CYCLES  = 1500;

    typedef struct {
        logic [15:0] speed;
        logic [15:0] steer;
        int          gap;
    } motion_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] hd;
    } pose_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        speed;
    logic signed [15:0] steer;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    kinematic_bicycle_pose_step dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .speed(speed), .steer(steer),
        .out_valid(out_valid), .out_stall(out_stall),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state and configuration shadow.
    longint wb_reg;
    longint dt_reg;
    longint x_pos = 0;
    longint y_pos = 0;
    longint yaw_pos = 0;

    motion_t motion_q[$];
    pose_t   pose_q[$];
    int      mismatches = 0;
    int      n_sent = 0;
    int      n_seen = 0;
    int      idle_cycles;
    bit      hold_req = 1'b0;
    bit      stim_done;

    // Clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // Sixteen-step rotation; angle in Q16 radians, outputs Q2.30 clamped.
    task automatic rotate(input longint ang, output longint c, output longint s);
        longint rx;
        longint ry;
        longint dx;
        longint dy;
        longint z;
        longint atan_v[16];
        atan_v = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                   256, 128, 64, 32, 16, 8, 4, 2};
        rx = ROT_START;
        ry = 0;
        z = ang;
        for (int i = 0; i < 16; i++)
        begin
            dx = shr_floor(ry, i);
            dy = shr_floor(rx, i);
            if (z >= 0)
            begin
                rx -= dx; ry += dy; z -= atan_v[i];
            end
            else
            begin
                rx += dx; ry -= dy; z += atan_v[i];
            end
        end
        c = (rx > UNIT_Q30) ? UNIT_Q30 : (rx < -UNIT_Q30) ? -UNIT_Q30 : rx;
        s = (ry > UNIT_Q30) ? UNIT_Q30 : (ry < -UNIT_Q30) ? -UNIT_Q30 : ry;
    endtask

    // Position increment: v*dt times a trig value, rounded to Q16.
    function automatic longint travel_step(longint vdt, longint trig);
        logic [127:0] prod;
        longint mag;
        mag = trig < 0 ? -trig : trig;
        prod = (128'(vdt) * 128'(mag) + (128'd1 << 41)) >> 42;
        return trig < 0 ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint sat_q16(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Advance the predicted pose by one beat and return the expected result.
    task automatic advance_pose(input logic [15:0] v_in, input logic [15:0] st_in,
                                output pose_t res);
        longint v;
        longint st;
        longint wb;
        longint z;
        longint c;
        longint s;
        longint tc;
        longint ts;
        longint vdt;
        longint tmag;
        longint delta;
        longint t;
        logic [127:0] mag;
        logic [127:0] den;
        logic [127:0] q;
        bit flip;
        bit neg_st;
        v = v_in;
        st = longint'($signed(st_in));
        wb = (wb_reg == 0) ? 1 : wb_reg;
        if (st > STEER_LIMIT) st = STEER_LIMIT;
        if (st < -STEER_LIMIT) st = -STEER_LIMIT;
        flip = 1'b0;
        if (yaw_pos > HEAD_HALF_PI)
        begin
            z = (yaw_pos - HEAD_PI) * 8; flip = 1'b1;
        end
        else if (yaw_pos < -HEAD_HALF_PI)
        begin
            z = (yaw_pos + HEAD_PI) * 8; flip = 1'b1;
        end
        else
            z = yaw_pos * 8;
        rotate(z, c, s);
        if (flip)
        begin
            c = -c; s = -s;
        end
        vdt = v * dt_reg;
        x_pos = sat_q16(x_pos + travel_step(vdt, c));
        y_pos = sat_q16(y_pos + travel_step(vdt, s));
        // Heading change from the steering tangent.
        neg_st = st < 0;
        rotate((neg_st ? -st : st) * 4, tc, ts);
        if (ts < 0) ts = 0;
        if (tc < TAN_COS_MIN) tc = TAN_COS_MIN;
        tmag = (ts <<< 16) / tc;
        mag = 128'(v) * 128'(tmag) * 128'(dt_reg);
        den = 128'(wb) << 19;
        q = (mag + (den >> 1)) / den;
        delta = neg_st ? -longint'(q) : longint'(q);
        t = (yaw_pos + HEAD_PI + delta) % HEAD_TWO_PI;
        if (t < 0) t += HEAD_TWO_PI;
        yaw_pos = t - HEAD_PI;
        res.x = x_pos[31:0];
        res.y = y_pos[31:0];
        res.hd = yaw_pos[15:0];
    endtask

    task automatic add_motion(input logic [15:0] v, input logic [15:0] st, input int gap);
        motion_t m;
        m.speed = v;
        m.steer = st;
        m.gap = gap;
        motion_q.push_back(m);
    endtask

    // Register write: setup then access cycle, changed on the falling edge.
    task automatic reg_write(input logic [2:0] addr, input logic [15:0] val);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = {16'd0, val};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == ADDR_WHEELBASE)
            wb_reg = val;
        else
            dt_reg = val;
    endtask

    // Wait until every sent beat has its result, then let the block settle.
    task automatic wait_drained();
        while (motion_q.size() != 0 || pose_q.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_run(input int count);
        logic [15:0] v;
        logic [15:0] st;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 5))
                0: v = 16'($urandom);
                1: v = 16'($urandom_range(0, 255));
                default: v = 16'($urandom_range(0, 16384));
            endcase
            case ($urandom_range(0, 6))
                0: st = 16'($urandom);
                1: st = ($urandom_range(0, 1) != 0) ? 16'sd22938 : -16'sd22938;
                default: st = 16'(longint'($urandom_range(0, 2 * STEER_LIMIT)) - STEER_LIMIT);
            endcase
            add_motion(v, st, ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 9)));
        end
    endtask

    // Accept flag sampled at the rising edge for the driver.
    logic in_stall_q;
    int   gap_left;
    bit   gap_armed;

    always @(posedge clk)
    begin
        in_stall_q <= in_stall;
    end

    // Driver: one beat at a time from the pending queue, after its own gap.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            speed <= '0;
            steer <= '0;
            gap_left = 0;
            gap_armed = 1'b0;
        end
        else if (in_valid && !in_stall_q)
        begin
            // Beat taken at the last rising edge.
            in_valid <= 1'b0;
            gap_armed = 1'b0;
        end
        else if (!in_valid && motion_q.size() != 0)
        begin
            if (!gap_armed)
            begin
                gap_left = motion_q[0].gap;
                gap_armed = 1'b1;
            end
            if (gap_left == 0)
            begin
                speed <= motion_q[0].speed;
                steer <= motion_q[0].steer;
                in_valid <= 1'b1;
            end
            else
                gap_left--;
        end
    end

    // Record accepted beats and their predicted results.
    always @(posedge clk)
    begin
        pose_t p;
        if (rst_n && in_valid && !in_stall)
        begin
            advance_pose(speed, steer, p);
            pose_q.push_back(p);
            void'(motion_q.pop_front());
            n_sent++;
        end
    end

    // Receiver stall: random per beat, with a long hold-off on request.
    int stall_left;
    int hold_left;
    bit hold_taken;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            stall_left = 0;
            hold_left = 0;
            hold_taken = 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            out_stall <= (stall_left != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: compare each accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_seen++;
            if (pose_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat x=%0d y=%0d hd=%0d",
                             pos_x, pos_y, heading);
            end
            else
            begin
                e = pose_q.pop_front();
                if (e.x !== pos_x || e.y !== pos_y || e.hd !== heading)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat %0d: expected x=%0d y=%0d hd=%0d, %s",
                                 n_seen, $signed(e.x), $signed(e.y), $signed(e.hd),
                                 $sformatf("got x=%0d y=%0d hd=%0d",
                                           pos_x, pos_y, heading));
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_left > 0)
            idle_cycles <= 0;
        else if (!stim_done || pose_q.size() != 0)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("watchdog expired with %0d results pending", pose_q.size());
                $display("** kinematic_bicycle_pose_step: FAILED **");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        wb_reg = 1229; dt_reg = 1311;
        stim_done = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats at reset settings: field extremes and clamp cases.
        add_motion(16'd0, 16'sd0, 0);
        add_motion(16'hFFFF, 16'sd0, 0);
        add_motion(16'hFFFF, 16'sd22938, 1);
        add_motion(16'hFFFF, -16'sd22938, 0);
        add_motion(16'h8000, 16'sh7FFF, 3);
        add_motion(16'h1000, 16'sh8000, 0);
        add_motion(16'h1000, 16'sd22939, 0);
        add_motion(16'h1000, -16'sd22939, 2);
        add_motion(16'hFFFF, 16'sd1, 0);
        add_motion(16'hFFFF, -16'sd1, 0);
        for (int i = 0; i < 8; i++)
            add_motion(16'hFFFF, 16'sd22938, 0);
        wait_drained();

        // Zero wheelbase and zero time step cases.
        reg_write(ADDR_WHEELBASE, 16'd0);
        reg_write(ADDR_TIME_STEP, 16'd0);
        add_motion(16'hFFFF, 16'sd22938, 0);
        add_motion(16'h5555, -16'sd12000, 0);
        wait_drained();

        // Extreme settings: long step, tiny and huge wheelbase, to drive saturation.
        reg_write(ADDR_TIME_STEP, 16'hFFFF);
        reg_write(ADDR_WHEELBASE, 16'd1);
        add_motion(16'hAAAA, 16'sd5461, 0);
        add_motion(16'h5555, -16'sd300, 1);
        wait_drained();
        reg_write(ADDR_WHEELBASE, 16'hFFFF);
        random_run(60);
        for (int i = 0; i < 20; i++)
            add_motion(16'hFFFF, 16'sd0, 0);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering beats.
        reg_write(ADDR_WHEELBASE, 16'd1229);
        reg_write(ADDR_TIME_STEP, 16'd1311);
        hold_req = 1'b1;
        random_run(8);
        wait_drained();

        // Random phases across several settings; sender pauses between them.
        for (int ph = 0; ph < 4; ph++)
        begin
            reg_write(ADDR_WHEELBASE, 16'($urandom_range(1, 65535)));
            reg_write(ADDR_TIME_STEP, (ph == 0) ? 16'd1 : 16'($urandom_range(1, 65535)));
            random_run(85);
            wait_drained();
        end
        stim_done = 1'b1;

        $display("Run covered %0d pose steps over register extremes, zero cases and clamps,",
                 n_sent);
        $display("with random stalls on both sides and a long receiver hold-off.");
        if (mismatches == 0 && pose_q.size() == 0)
            $display("** kinematic_bicycle_pose_step: PASSED **");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, pose_q.size());
            $display("** kinematic_bicycle_pose_step: FAILED **");
        end
        $finish;
    end

endmodule
